// ===== rtl/core/mhpq_pkg.sv =====
// Shared types and constants for the max-heap priority queue.
// No dependencies; used by mhpq_cell and max_heap_priority_queue_core.
`default_nettype none

package mhpq_pkg;

  localparam int unsigned KEY_W        = 16;
  localparam int unsigned TAG_W        = 16;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned IN_DATA_W    = 32;
  localparam int unsigned OUT_DATA_W   = 40;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CAPACITY_DEF = 127;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Work token walking down the row of level cells.
  typedef struct packed {
    logic   valid;
    op_e    op;
    logic   placed;  // insert: carried entry already displaced one on the path
    entry_t ent;     // insert: carried entry; remove: former last entry
  } token_t;

  // Write request from a cell to the level above it.
  typedef struct packed {
    logic   we;
    entry_t ent;
  } wback_t;

endpackage

`default_nettype wire

// ===== rtl/core/mhpq_cell.sv =====
// One heap level: entry memory of that level plus the per-level sift step.
// Depends on mhpq_pkg. Instantiated once per level by max_heap_priority_queue_core.
`default_nettype none

module mhpq_cell #(
  parameter int unsigned LEVEL      = 0,
  parameter int unsigned NUM_LEVELS = 7,
  parameter int unsigned IDX_W      = 7,
  parameter int unsigned LVL_W      = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // token from the level above
  input  mhpq_pkg::token_t      tok_i,
  input  logic [IDX_W-1:0]      tok_pos_i,   // insert: target slot; remove: hole one level up
  input  logic [LVL_W-1:0]      tok_lvl_i,   // insert: level of target slot
  input  logic [IDX_W-1:0]      tok_cnt_i,   // remove: entries left after removal
  // token to the level below
  output mhpq_pkg::token_t      tok_o,
  output logic [IDX_W-1:0]      tok_pos_o,
  output logic [LVL_W-1:0]      tok_lvl_o,
  output logic [IDX_W-1:0]      tok_cnt_o,
  // write request from the level below, and to the level above
  input  mhpq_pkg::wback_t      wb_i,
  input  logic [IDX_W-1:0]      wb_pos_i,
  output mhpq_pkg::wback_t      wb_o,
  output logic [IDX_W-1:0]      wb_pos_o,
  // broadcast read of the last slot and the root
  input  logic                  fetch_i,
  input  logic [IDX_W-1:0]      fetch_pos_i,
  input  logic [LVL_W-1:0]      fetch_lvl_i,
  output mhpq_pkg::entry_t      last_o,
  output mhpq_pkg::entry_t      root_o,
  output logic                  done_o
);

  localparam int unsigned AW       = (LEVEL == 0) ? 1 : LEVEL;
  localparam int unsigned DEPTH    = 1 << AW;
  localparam bit          IS_LAST  = (LEVEL == NUM_LEVELS - 1);
  localparam logic [LVL_W-1:0] LVL_THIS = LVL_W'(LEVEL);

  // offset of a slot inside its level: the bits below the leading one
  function automatic logic [AW-1:0] offs(input logic [IDX_W:0] p);
    logic [AW-1:0] r;
    r = (LEVEL == 0) ? '0 : p[AW-1:0];
    return r;
  endfunction

  mhpq_pkg::entry_t mem_q [DEPTH];
  mhpq_pkg::entry_t rd_a_q, rd_b_q;

  logic [AW-1:0]    addr_a, addr_b, waddr;
  logic             we;
  mhpq_pkg::entry_t wdata;

  logic [LVL_W-1:0] sh;
  logic [IDX_W-1:0] ins_node;
  logic             fetch_hit;

  mhpq_pkg::token_t s1_tok_q;
  logic [IDX_W-1:0] s1_pos_q, s1_node_q, s1_cnt_q;
  logic [LVL_W-1:0] s1_lvl_q;
  logic             fetch_hit_q;

  mhpq_pkg::token_t tok_d, tok_q;
  logic [IDX_W-1:0] pos_d, pos_q, cnt_q, wb_pos_d, wb_pos_q;
  logic [LVL_W-1:0] lvl_q;
  mhpq_pkg::wback_t wb_d, wb_q;
  logic             done_d, done_q;

  logic             own_we;
  logic [AW-1:0]    own_addr;
  mhpq_pkg::entry_t own_data;

  logic [IDX_W:0]   c0, c1, c_pick;
  logic             v0, v1, pick1;
  mhpq_pkg::entry_t child;

  // ---- read side: address from fetch, insert path or children of the hole
  assign sh        = tok_lvl_i - LVL_THIS;
  assign ins_node  = tok_pos_i >> sh;
  assign fetch_hit = fetch_i && (fetch_lvl_i == LVL_THIS);

  always_comb begin
    if (fetch_hit) begin
      addr_a = offs({1'b0, fetch_pos_i});
    end else if (tok_i.op == mhpq_pkg::OP_INSERT) begin
      addr_a = offs({1'b0, ins_node});
    end else begin
      addr_a = offs({tok_pos_i, 1'b0});
    end
    if (fetch_i) begin
      addr_b = '0;
    end else begin
      addr_b = offs({tok_pos_i, 1'b1});
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[addr_a];
    rd_b_q <= mem_q[addr_b];
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tok_q    <= '0;
      fetch_hit_q <= 1'b0;
    end else begin
      s1_tok_q    <= tok_i;
      fetch_hit_q <= fetch_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pos_q  <= tok_pos_i;
    s1_node_q <= ins_node;
    s1_lvl_q  <= tok_lvl_i;
    s1_cnt_q  <= tok_cnt_i;
  end

  // ---- evaluate step: read data is valid now
  assign c0     = {s1_pos_q, 1'b0};
  assign c1     = {s1_pos_q, 1'b1};
  assign v0     = c0 <= {1'b0, s1_cnt_q};
  assign v1     = c1 <= {1'b0, s1_cnt_q};
  assign pick1  = v1 && (rd_b_q.key > rd_a_q.key);  // ties go left
  assign child  = pick1 ? rd_b_q : rd_a_q;
  assign c_pick = pick1 ? c1 : c0;

  always_comb begin
    tok_d    = '0;
    pos_d    = s1_pos_q;
    wb_d     = '0;
    wb_pos_d = s1_pos_q;
    done_d   = 1'b0;
    own_we   = 1'b0;
    own_addr = offs({1'b0, s1_node_q});
    own_data = s1_tok_q.ent;
    if (s1_tok_q.valid) begin
      if (s1_tok_q.op == mhpq_pkg::OP_INSERT) begin
        if (s1_lvl_q == LVL_THIS) begin
          // free slot at the end of the heap
          own_we = 1'b1;
          done_d = 1'b1;
        end else begin
          tok_d = s1_tok_q;
          if (s1_tok_q.placed || (s1_tok_q.ent.key > rd_a_q.key)) begin
            own_we       = 1'b1;
            tok_d.ent    = rd_a_q;
            tok_d.placed = 1'b1;
          end
        end
      end else if (LEVEL == 0) begin
        // hole starts at the root; children live one level down
        tok_d = s1_tok_q;
      end else begin
        wb_d.we = 1'b1;
        if (!v0 || (s1_tok_q.ent.key >= child.key)) begin
          wb_d.ent = s1_tok_q.ent;
          done_d   = 1'b1;
        end else begin
          wb_d.ent = child;
          if (IS_LAST) begin
            own_we   = 1'b1;
            own_addr = offs(c_pick);
            done_d   = 1'b1;
          end else begin
            tok_d = s1_tok_q;
            pos_d = IDX_W'(c_pick);
          end
        end
      end
    end
  end

  // own step and write-back from below never hit the same cycle
  assign we    = own_we | wb_i.we;
  assign waddr = own_we ? own_addr : offs({1'b0, wb_pos_i});
  assign wdata = own_we ? own_data : wb_i.ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      wb_q   <= '0;
      done_q <= 1'b0;
    end else begin
      tok_q  <= tok_d;
      wb_q   <= wb_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    lvl_q    <= s1_lvl_q;
    cnt_q    <= s1_cnt_q;
    wb_pos_q <= wb_pos_d;
  end

  assign tok_o     = tok_q;
  assign tok_pos_o = pos_q;
  assign tok_lvl_o = lvl_q;
  assign tok_cnt_o = cnt_q;
  assign wb_o      = wb_q;
  assign wb_pos_o  = wb_pos_q;
  assign done_o    = done_q;
  assign last_o    = fetch_hit_q ? rd_a_q : '0;
  assign root_o    = rd_b_q;

endmodule

`default_nettype wire

// ===== rtl/core/max_heap_priority_queue_core.sv =====
// Binary max-heap priority queue: controller plus a row of per-level cells.
// Depends on mhpq_pkg and mhpq_cell.
//
// Usage:
//   Input beats on s_axis: tuser = op (0 insert, 1 remove max), tdata = key, tag.
//   One result beat per input beat on m_axis: tuser = status (0 ok, 1 insert
//   rejected full, 2 remove rejected empty), tdata = removed key, removed tag
//   (both 0 unless a remove succeeded), entry count after the operation.
//   Heap level L lives in cell L; a token walks the row top-down and every cell
//   handles it with a registered memory read, then a compare and write. The
//   result is ready when an insert has written its target level or a remove
//   has ended its sift; a remove of the only entry and rejected beats skip
//   the walk. Input is taken again once the result is registered.
//   One operation is in flight at a time; s_axis_tready is high while idle.
//   The result sits in an output register, so the next beat is taken while a
//   result still waits; a stalled m_axis holds the result and the finished
//   operation behind it.
//   Reset empties the queue at once; entry memories are not cleared.
`default_nettype none

module max_heap_priority_queue_core #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [mhpq_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // key[15:0], tag[31:16]
  input  logic                                  s_axis_tuser,  // op[0]
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [mhpq_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // out_key[15:0], out_tag[31:16],
                                                               // count[38:32], zero[39]
  output logic [mhpq_pkg::STATUS_W-1:0]         m_axis_tuser   // status[1:0]
);

  localparam int unsigned IDX_W      = $clog2(CAPACITY + 1);
  localparam int unsigned NUM_LEVELS = IDX_W;
  localparam int unsigned LVL_W      = $clog2(NUM_LEVELS);
  localparam logic [IDX_W-1:0] CAP   = IDX_W'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_LAST  = 5'b00100,
    S_WALK  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     count_q, count_d;

  mhpq_pkg::token_t     inj_tok_q, inj_tok_d;
  logic [IDX_W-1:0]     inj_pos_q, inj_pos_d, inj_cnt_q, inj_cnt_d;
  logic [LVL_W-1:0]     inj_lvl_q, inj_lvl_d;

  logic                 fetch_q, fetch_d;
  logic [IDX_W-1:0]     fetch_pos_q, fetch_pos_d;
  logic [LVL_W-1:0]     fetch_lvl_q, fetch_lvl_d;

  mhpq_pkg::status_e    res_status_q, res_status_d;
  mhpq_pkg::entry_t     res_ent_q, res_ent_d;

  logic                 out_valid_q, out_valid_d;
  mhpq_pkg::status_e    out_status_q, out_status_d;
  mhpq_pkg::entry_t     out_ent_q, out_ent_d;
  logic [IDX_W-1:0]     out_count_q, out_count_d;

  logic                 in_acc;
  mhpq_pkg::op_e        in_op;
  logic [IDX_W-1:0]     enc_val;
  logic [LVL_W-1:0]     enc_lvl;
  mhpq_pkg::entry_t     last_ent;
  logic                 any_done;

  // cell row
  mhpq_pkg::token_t     tok      [NUM_LEVELS+1];
  logic [IDX_W-1:0]     tok_pos  [NUM_LEVELS+1];
  logic [LVL_W-1:0]     tok_lvl  [NUM_LEVELS+1];
  logic [IDX_W-1:0]     tok_cnt  [NUM_LEVELS+1];
  mhpq_pkg::wback_t     wb       [NUM_LEVELS+1];
  logic [IDX_W-1:0]     wb_pos   [NUM_LEVELS+1];
  mhpq_pkg::entry_t     last_arr [NUM_LEVELS];
  mhpq_pkg::entry_t     root_arr [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] done_vec;

  assign tok[0]             = inj_tok_q;
  assign tok_pos[0]         = inj_pos_q;
  assign tok_lvl[0]         = inj_lvl_q;
  assign tok_cnt[0]         = inj_cnt_q;
  assign wb[NUM_LEVELS]     = '0;
  assign wb_pos[NUM_LEVELS] = '0;

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
    mhpq_cell #(
      .LEVEL      (g),
      .NUM_LEVELS (NUM_LEVELS),
      .IDX_W      (IDX_W),
      .LVL_W      (LVL_W)
    ) u_level (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_i       (tok[g]),
      .tok_pos_i   (tok_pos[g]),
      .tok_lvl_i   (tok_lvl[g]),
      .tok_cnt_i   (tok_cnt[g]),
      .tok_o       (tok[g+1]),
      .tok_pos_o   (tok_pos[g+1]),
      .tok_lvl_o   (tok_lvl[g+1]),
      .tok_cnt_o   (tok_cnt[g+1]),
      .wb_i        (wb[g+1]),
      .wb_pos_i    (wb_pos[g+1]),
      .wb_o        (wb[g]),
      .wb_pos_o    (wb_pos[g]),
      .fetch_i     (fetch_q),
      .fetch_pos_i (fetch_pos_q),
      .fetch_lvl_i (fetch_lvl_q),
      .last_o      (last_arr[g]),
      .root_o      (root_arr[g]),
      .done_o      (done_vec[g])
    );
  end

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_op  = mhpq_pkg::op_e'(s_axis_tuser);

  // level of a slot = index of its leading one
  assign enc_val = (in_op == mhpq_pkg::OP_INSERT) ? IDX_W'(count_q + 1'b1) : count_q;
  always_comb begin
    enc_lvl = '0;
    for (int i = 0; i < IDX_W; i++) begin
      if (enc_val[i]) begin
        enc_lvl = LVL_W'(i);
      end
    end
  end

  always_comb begin
    last_ent = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      last_ent = last_ent | last_arr[i];
    end
  end

  assign any_done = |done_vec;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    inj_tok_d    = '0;
    inj_pos_d    = inj_pos_q;
    inj_lvl_d    = inj_lvl_q;
    inj_cnt_d    = inj_cnt_q;
    fetch_d      = 1'b0;
    fetch_pos_d  = fetch_pos_q;
    fetch_lvl_d  = fetch_lvl_q;
    res_status_d = res_status_q;
    res_ent_d    = res_ent_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_ent_d    = out_ent_q;
    out_count_d  = out_count_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_status_d = mhpq_pkg::ST_OK;
          res_ent_d    = '0;
          if (in_op == mhpq_pkg::OP_INSERT) begin
            if (count_q >= CAP) begin
              res_status_d = mhpq_pkg::ST_FULL;
              state_d      = S_DONE;
            end else begin
              inj_tok_d.valid  = 1'b1;
              inj_tok_d.op     = mhpq_pkg::OP_INSERT;
              inj_tok_d.placed = 1'b0;
              inj_tok_d.ent    = '{key: s_axis_tdata[15:0], tag: s_axis_tdata[31:16]};
              inj_pos_d        = enc_val;
              inj_lvl_d        = enc_lvl;
              count_d          = enc_val;
              state_d          = S_WALK;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = mhpq_pkg::ST_EMPTY;
              state_d      = S_DONE;
            end else begin
              fetch_d     = 1'b1;
              fetch_pos_d = count_q;
              fetch_lvl_d = enc_lvl;
              count_d     = count_q - 1'b1;
              state_d     = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        state_d = S_LAST;
      end
      S_LAST: begin
        res_ent_d = root_arr[0];
        if (count_q == '0) begin
          state_d = S_DONE;
        end else begin
          // former last entry drops into the root hole
          inj_tok_d.valid  = 1'b1;
          inj_tok_d.op     = mhpq_pkg::OP_REMOVE;
          inj_tok_d.placed = 1'b0;
          inj_tok_d.ent    = last_ent;
          inj_pos_d        = IDX_W'(1);
          inj_cnt_d        = count_q;
          state_d          = S_WALK;
        end
      end
      S_WALK: begin
        if (any_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_ent_d    = res_ent_q;
          out_count_d  = count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      inj_tok_q   <= '0;
      fetch_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      inj_tok_q   <= inj_tok_d;
      fetch_q     <= fetch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inj_pos_q    <= inj_pos_d;
    inj_lvl_q    <= inj_lvl_d;
    inj_cnt_q    <= inj_cnt_d;
    fetch_pos_q  <= fetch_pos_d;
    fetch_lvl_q  <= fetch_lvl_d;
    res_status_q <= res_status_d;
    res_ent_q    <= res_ent_d;
    out_status_q <= out_status_d;
    out_ent_q    <= out_ent_d;
    out_count_q  <= out_count_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {1'b0, mhpq_pkg::COUNT_W'(out_count_q), out_ent_q.tag, out_ent_q.key};

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP)
    else $error("entry count above capacity");

  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(done_vec))
    else $error("more than one level finished at once");

  a_done_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_done |-> (state_q == S_WALK))
    else $error("level finished outside a walk");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_op == mhpq_pkg::OP_INSERT) && (count_q < CAP))
      |=> (count_q == IDX_W'($past(count_q) + 1'b1)))
    else $error("accepted insert did not grow the heap");

  a_remove_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_op == mhpq_pkg::OP_REMOVE) && (count_q != '0)) |=> fetch_q)
    else $error("accepted remove did not read last slot");
`endif

endmodule

`default_nettype wire
